/* src/pts_pkg.sv */
// ============================================================================
// pts_pkg - shared types and constants of the periodic task scheduler
// Command and result beat layouts, result kinds, status codes, slot limits.
// ============================================================================
`default_nettype none

package pts_pkg;

    // Slot table limits: a task id is 4 bits, so at most 16 slots
    localparam int SLOT_ROOM     = 16;
    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_W        = 32;
    localparam int TASK_ID_W     = 4;

    // Command codes
    localparam logic CMD_RUN = 1'b0;
    localparam logic CMD_ADD = 1'b1;

    // Add answer status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_DONE  = 2'd2
    } pts_kind_t;

    // Command beat
    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] task_period;
        logic              repeats;
        logic              start_enabled;
    } pts_req_t;

    // Result beat
    typedef struct packed {
        pts_kind_t            kind;
        logic [TASK_ID_W-1:0] task_id;
        logic                 status;
        logic                 last;
    } pts_rsp_t;

endpackage

`default_nettype wire

/* src/periodic_task_scheduler_unit.sv */
// ============================================================================
// periodic_task_scheduler_unit - slot table scheduler for periodic tasks
// Adds tasks to a slot table and scans it at a given time, firing due tasks.
// ============================================================================
// A command beat is taken when start is high and busy is low. An add command
// answers in the next cycle with the slot index or a table-full status. A run
// command holds busy through its scan of the slots in use and the done state
// (busy stays low for a run on an empty table, which answers done in the next
// cycle): the slot memory (period and due time) has one read port, so the scan
// visits one slot per cycle, reading the next slot while it writes back the due
// time of the current one if it fires, and the done state closes the run.
// Results come at most one per cycle on result with result_valid high for exactly
// one cycle; they cannot be held off. A run gives one fired result per due
// task, then a done result marked last. The table holds NUM_SLOTS slots,
// clamped to 1..16.
`default_nettype none

module periodic_task_scheduler_unit #(
    parameter int NUM_SLOTS = pts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pts_pkg::pts_req_t request,
    output logic                  result_valid,
    output pts_pkg::pts_rsp_t     result
);

    import pts_pkg::*;

    localparam int SLOT_CAP = (NUM_SLOTS < 1) ? 1 :
                              ((NUM_SLOTS > SLOT_ROOM) ? SLOT_ROOM : NUM_SLOTS);
    localparam int IDX_W    = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
    localparam int CNT_W    = $clog2(SLOT_CAP + 1);
    localparam int ENTRY_W  = 2 * TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } pts_state_t;

    pts_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]     slots_used_reg, slots_used_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic [SLOT_CAP-1:0]  enabled_reg, enabled_next;
    logic [SLOT_CAP-1:0]  periodic_reg, periodic_next;
    logic                 result_valid_reg, result_valid_next;
    pts_rsp_t             result_reg, result_next;

    // Slot memory port signals; entry = {period, due}
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [TIME_W-1:0]    rd_period;
    logic [TIME_W-1:0]    rd_due;
    logic                 fire;
    logic [CNT_W-1:0]     scan_idx_inc;

    pts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_CAP),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_period    = ram_rdata[ENTRY_W-1:TIME_W];
    assign rd_due       = ram_rdata[TIME_W-1:0];
    assign scan_idx_inc = CNT_W'(scan_idx_reg) + CNT_W'(1);

    // Slot under scan is due
    assign fire = enabled_reg[scan_idx_reg] && (last_time_reg >= rd_due);

    // Command decode and scan sequencer
    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        slots_used_next   = slots_used_reg;
        last_time_next    = last_time_reg;
        enabled_next      = enabled_reg;
        periodic_next     = periodic_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = scan_idx_reg;
        ram_wdata         = {rd_period, last_time_reg + rd_period};
        ram_re            = 1'b0;
        ram_raddr         = scan_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (request.cmd == CMD_ADD)
                    begin
                        result_valid_next   = 1'b1;
                        result_next.kind    = KIND_ADD;
                        result_next.last    = 1'b1;
                        if (slots_used_reg < CNT_W'(SLOT_CAP))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = slots_used_reg[IDX_W-1:0];
                            ram_wdata = {request.task_period,
                                         last_time_reg + request.task_period};
                            enabled_next[slots_used_reg[IDX_W-1:0]] =
                                request.start_enabled;
                            periodic_next[slots_used_reg[IDX_W-1:0]] =
                                request.repeats;
                            slots_used_next     = slots_used_reg + CNT_W'(1);
                            result_next.task_id = TASK_ID_W'(slots_used_reg);
                            result_next.status  = STATUS_OK;
                        end
                        else
                        begin
                            result_next.task_id = '0;
                            result_next.status  = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        last_time_next = request.now_time;
                        if (slots_used_reg == '0)
                        begin
                            result_valid_next   = 1'b1;
                            result_next.kind    = KIND_DONE;
                            result_next.task_id = '0;
                            result_next.status  = STATUS_OK;
                            result_next.last    = 1'b1;
                        end
                        else
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = '0;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // evaluate the slot read last cycle, write back if it fires
                if (fire)
                begin
                    ram_we              = 1'b1;
                    result_valid_next   = 1'b1;
                    result_next.kind    = KIND_FIRED;
                    result_next.task_id = TASK_ID_W'(scan_idx_reg);
                    result_next.status  = STATUS_OK;
                    result_next.last    = 1'b0;
                    if (!periodic_reg[scan_idx_reg])
                    begin
                        enabled_next[scan_idx_reg] = 1'b0;
                    end
                end
                // fetch the next slot, or close the run
                if (scan_idx_inc < slots_used_reg)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_idx_inc[IDX_W-1:0];
                    scan_idx_next = scan_idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                result_valid_next   = 1'b1;
                result_next.kind    = KIND_DONE;
                result_next.task_id = '0;
                result_next.status  = STATUS_OK;
                result_next.last    = 1'b1;
                state_next          = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            scan_idx_reg     <= '0;
            slots_used_reg   <= '0;
            last_time_reg    <= '0;
            enabled_reg      <= '0;
            periodic_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            slots_used_reg   <= slots_used_next;
            last_time_reg    <= last_time_next;
            enabled_reg      <= enabled_next;
            periodic_reg     <= periodic_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Scan index stays inside the used part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_idx_reg) < slots_used_reg))
        else $error("scan index beyond used slots");

    // Closing a run always yields a done beat marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=>
            (result_valid && (result.kind == KIND_DONE) && result.last))
        else $error("run did not end with done beat");

    // A fired beat only comes out of the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_FIRED)) |->
            ($past(state_reg) == ST_SCAN) && !result.last)
        else $error("fired beat outside of scan");

endmodule

`default_nettype wire

/* src/pts_ram.sv */
// ============================================================================
// pts_ram - generic single-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

/* tb/sv/periodic_task_scheduler_unit_tb.sv */
// ============================================================================
// periodic_task_scheduler_unit_tb - self-checking bench for the task scheduler
// Drives add and run commands, keeps a shadow slot table to predict add
// answers, fired slots and done beats, and checks every result beat in order.
// ============================================================================

module periodic_task_scheduler_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 405;

    // ------------------------------------------------------------------------
    // Shadow slot table and queue of awaited result beats
    // ------------------------------------------------------------------------
    class task_table_checker;
        int unsigned cap;
        bit          slot_en[SLOT_ROOM];
        bit          slot_rep[SLOT_ROOM];
        bit [31:0]   slot_per[SLOT_ROOM];
        bit [31:0]   slot_due[SLOT_ROOM];
        int unsigned n_used;
        bit [31:0]   seen_time;
        pts_rsp_t    awaited[$];
        int unsigned mismatches;
        int unsigned n_checked;
        int unsigned n_fired;
        int unsigned n_full;

        function new(int slots);
            cap = (slots < 1) ? 1 : ((slots > SLOT_ROOM) ? SLOT_ROOM : slots);
            foreach (slot_en[i])
            begin
                slot_en[i]  = 1'b0;
                slot_rep[i] = 1'b0;
            end
            n_used     = 0;
            seen_time  = '0;
            mismatches = 0;
            n_checked  = 0;
            n_fired    = 0;
            n_full     = 0;
        endfunction

        function void await_beat(pts_kind_t k, int id, logic st, logic lst);
            pts_rsp_t r;
            r.kind    = k;
            r.task_id = TASK_ID_W'(id);
            r.status  = st;
            r.last    = lst;
            awaited.push_back(r);
        endfunction

        // Accepted command: update the table and queue its result beats
        function void log_command(pts_req_t req);
            if (req.cmd == CMD_ADD)
            begin
                if (n_used < cap)
                begin
                    slot_en[n_used]  = req.start_enabled;
                    slot_rep[n_used] = req.repeats;
                    slot_per[n_used] = req.task_period;
                    slot_due[n_used] = seen_time + req.task_period;
                    await_beat(KIND_ADD, n_used, STATUS_OK, 1'b1);
                    n_used++;
                end
                else
                begin
                    await_beat(KIND_ADD, 0, STATUS_FULL, 1'b1);
                end
            end
            else
            begin
                // Scan used slots in order; plain unsigned compare, no wrap care
                seen_time = req.now_time;
                for (int i = 0; i < n_used; i++)
                begin
                    if (slot_en[i] && req.now_time >= slot_due[i])
                    begin
                        slot_due[i] = req.now_time + slot_per[i];
                        if (!slot_rep[i])
                            slot_en[i] = 1'b0;
                        await_beat(KIND_FIRED, i, STATUS_OK, 1'b0);
                    end
                end
                await_beat(KIND_DONE, 0, STATUS_OK, 1'b1);
            end
        endfunction

        // Result beat: compare with the oldest awaited beat
        function void check_result(pts_rsp_t got);
            pts_rsp_t want;
            n_checked++;
            if (awaited.size() == 0)
            begin
                $error("unexpected result beat: kind %0d task_id %0d status %0d last %0d",
                       got.kind, got.task_id, got.status, got.last);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.task_id !== want.task_id)
            begin
                $error("task_id: expected %0d, got %0d", want.task_id, got.task_id);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
            if (want.kind == KIND_FIRED)
                n_fired++;
            if (want.kind == KIND_ADD && want.status == STATUS_FULL)
                n_full++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    pts_req_t request;
    logic     result_valid;
    pts_rsp_t result;

    task_table_checker table_chk;
    int unsigned       n_adds;
    int unsigned       n_runs;
    int unsigned       burst_left;
    int unsigned       idle_cycles;

    periodic_task_scheduler_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            table_chk.check_result(result);
    end

    // Watchdog: cycles with no command taken and no result beat
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------------
    function automatic pts_req_t run_at(bit [31:0] t);
        pts_req_t r;
        r.cmd           = CMD_RUN;
        r.now_time      = t;
        r.task_period   = $urandom;
        r.repeats       = 1'($urandom_range(0, 1));
        r.start_enabled = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic pts_req_t add_task(bit [31:0] per, bit rep, bit en);
        pts_req_t r;
        r.cmd           = CMD_ADD;
        r.now_time      = $urandom;
        r.task_period   = per;
        r.repeats       = rep;
        r.start_enabled = en;
        return r;
    endfunction

    // Gap after a beat: mostly none or short, a few long, some bursts
    function automatic int pick_gap();
        int p;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one command beat, wait for acceptance, then idle for the picked gap, if any
    task automatic issue(input pts_req_t req);
        int gap;
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        table_chk.log_command(req);
        if (req.cmd == CMD_ADD)
            n_adds++;
        else
            n_runs++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        bit [31:0] clock_now;
        bit [31:0] per;
        int        p;

        table_chk  = new(NUM_SLOTS);
        n_adds     = 0;
        n_runs     = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, period extremes, one-shot, disabled task
        issue(run_at(32'd0));
        issue(add_task(32'd0, 1'b1, 1'b1));
        issue(add_task(32'hFFFF_FFFF, 1'b1, 1'b1));
        issue(add_task(32'd5, 1'b0, 1'b1));
        issue(add_task(32'd3, 1'b1, 1'b0));
        issue(run_at(32'd0));
        issue(run_at(32'd4));
        issue(run_at(32'd5));
        issue(run_at(32'd100));
        // Top of the time range, then wrap back to zero (no task is due)
        issue(run_at(32'hFFFF_FFFF));
        issue(run_at(32'd0));
        issue(run_at(32'hFFFF_FFFE));

        // Fill the table and go one past it for a full answer
        for (int k = 4; k <= int'(table_chk.cap); k++)
        begin
            per = (k % 4 == 3) ? 32'($urandom) : 32'($urandom_range(1, 25));
            issue(add_task(per, $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0));
        end

        // Random: mostly runs with a clock creeping forward, some jumps
        clock_now = 32'hFFFF_FFFE;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            p = $urandom_range(0, 99);
            if (p < 12)
            begin
                p = $urandom_range(0, 9);
                per = (p < 5) ? 32'($urandom_range(0, 40)) :
                      (p < 8) ? 32'($urandom) :
                      (p < 9) ? 32'd0 : 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
                issue(add_task(per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 72)
                    clock_now = clock_now + 32'($urandom_range(0, 30));
                else if (p < 84)
                    clock_now = clock_now + 32'($urandom_range(100, 5000));
                else if (p < 93)
                    clock_now = $urandom;
                else if (p < 98)
                    clock_now = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
                else
                    clock_now = 32'd0;
                issue(run_at(clock_now));
            end
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain, then watch a while for stray beats
        while (table_chk.awaited.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d commands: %0d adds (%0d answered full) and %0d scans.",
                 n_adds + n_runs, n_adds, table_chk.n_full, n_runs);
        $display("Checked %0d result beats, %0d of them fired tasks.",
                 table_chk.n_checked, table_chk.n_fired);
        if (table_chk.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
